/* design/u2l_pkg.sv */
package u2l_pkg;

   // Replacement byte after reset: a question mark.
   localparam logic [7:0] REPLACEMENT_RESET = 8'h3F;

   // Role of a raw byte in a UTF-8 sequence.
   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data;
      byte_class_type cls;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      eos;
   } queue_item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_head_type;

endpackage

/* design/utf8_to_latin1_decoder_top.sv */
// UTF-8 to Latin-1 decoder. Raw UTF-8 bytes enter one item at a time with an
// end-of-string flag; Latin-1 bytes leave, each tagged with run_last (last
// result caused by that input byte) and string_last (final result of the
// string). Unrepresentable or malformed input yields the byte held in the
// replacement register, which resets to a question mark. A front queue of
// QUEUE_DEPTH entries takes one byte per cycle while it is not full and
// classifies it; the back end produces one result per cycle from its output
// register while rsp_stall is low. A byte that completes nothing yields no
// result, so ordinary text runs at one byte per cycle when neither side
// stalls. A byte that breaks a pending sequence, or that carries the end
// mark behind an unfinished one, can yield up to four results and holds the
// back end until they are out, while the queue takes input until it is full.
module utf8_to_latin1_decoder_top import u2l_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic [7:0]     repl_ff;
   queue_head_type head;
   logic           pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPLACEMENT_RESET;
      end else if (csr_wr_en) begin
         repl_ff <= csr_wr_data;
      end
   end

   u2l_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .head              (head),
      .pop               (pop)
   );

   u2l_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .repl            (repl_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_last (rsp_string_last)
   );

endmodule

/* design/u2l_front.sv */
module u2l_front import u2l_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [7:0]     req_in_byte,
   input  logic           req_end_of_string,
   output queue_head_type head,
   input  logic           pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   queue_item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push;
   logic                   do_pop;
   queue_item_type         new_item;

   function automatic byte_class_type classify_byte(input logic [7:0] b);
      byte_class_type c;
      if (b[7] == 1'b0) begin
         c = CLS_ASCII;
      end else if (b[6] == 1'b0) begin
         c = CLS_CONT;
      end else if (b[5] == 1'b0) begin
         c = CLS_LEAD2;
      end else if (b[4] == 1'b0) begin
         c = CLS_LEAD3;
      end else if (b[3] == 1'b0) begin
         c = CLS_LEAD4;
      end else begin
         c = CLS_BAD;
      end
      return c;
   endfunction

   assign req_stall = (count_ff == FULL_CNT);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   assign new_item.entry.data = req_in_byte;
   assign new_item.entry.cls  = classify_byte(req_in_byte);
   assign new_item.eos        = req_end_of_string;

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* design/u2l_back.sv */
module u2l_back import u2l_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  logic [7:0]     repl,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_run_last,
   output logic           rsp_string_last
);

   typedef struct packed {
      logic       brk;
      logic [7:0] value;
      logic [2:0] use_cnt;
   } step_type;

   entry_type [3:0] win_ff, win_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic            eos_ff, eos_in;
   logic            active_ff, active_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            run_last_ff, run_last_in;
   logic            string_last_ff, string_last_in;

   entry_type [3:0] wwin;
   entry_type [3:0] rem;
   logic [2:0]      wn;
   logic [2:0]      rn;
   logic            weos;
   logic            wv;
   logic            out_free;
   logic            go;
   logic            last;
   step_type        st;
   step_type        st_next;

   // Decides what the oldest byte of the window yields. A break means the
   // sequence is still incomplete and must wait for more bytes.
   function automatic step_type decode_step(input entry_type [3:0] w,
                                            input logic [2:0] n,
                                            input logic eos,
                                            input logic [7:0] r);
      step_type   s;
      logic [2:0] need;
      logic       bad;
      s.brk     = 1'b0;
      s.value   = r;
      s.use_cnt = 3'd1;
      need      = 3'd1;
      bad       = 1'b0;
      case (w[0].cls)
         CLS_ASCII: s.value = w[0].data;
         CLS_LEAD2: need = 3'd2;
         CLS_LEAD3: need = 3'd3;
         CLS_LEAD4: need = 3'd4;
         default:   ;
      endcase
      if (need > 3'd1) begin
         for (int i = 1; i < 4; i++) begin
            if ((3'(i) < need) && (3'(i) < n) && (w[i].cls != CLS_CONT)) begin
               bad = 1'b1;
            end
         end
         if (!bad) begin
            if (n < need) begin
               s.brk = !eos;
            end else begin
               s.use_cnt = need;
               // Two-byte forms fit in Latin-1 when the top three value bits are zero.
               if (need == 3'd2 && w[0].data[4:2] == 3'b000) begin
                  s.value = {w[0].data[1:0], w[1].data[5:0]};
               end
            end
         end
      end
      return s;
   endfunction

   assign wv       = active_ff || head.valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wwin = win_ff;
      wn   = cnt_ff;
      weos = eos_ff;
      if (!active_ff) begin
         wwin[cnt_ff[1:0]] = head.item.entry;
         wn                = cnt_ff + 3'd1;
         weos              = head.item.eos;
      end
   end

   assign st = decode_step(wwin, wn, weos, repl);
   assign rn = wn - st.use_cnt;

   always_comb begin
      rem = wwin;
      case (st.use_cnt)
         3'd1:    rem = {wwin[3], wwin[3:1]};
         3'd2:    rem = {wwin[3], wwin[3], wwin[3:2]};
         3'd3:    rem = {wwin[3], wwin[3], wwin[3], wwin[3]};
         default: rem = wwin;
      endcase
   end

   // The item's last result is known when the rest would wait or is empty.
   assign st_next = decode_step(rem, rn, weos, repl);
   assign last    = (rn == 3'd0) || st_next.brk;

   assign go  = wv && (st.brk || out_free);
   assign pop = go && !active_ff;

   always_comb begin
      win_in         = win_ff;
      cnt_in         = cnt_ff;
      eos_in         = eos_ff;
      active_in      = active_ff;
      rsp_valid_in   = out_free ? 1'b0 : rsp_valid_ff;
      out_byte_in    = out_byte_ff;
      run_last_in    = run_last_ff;
      string_last_in = string_last_ff;
      if (go) begin
         eos_in = weos;
         if (st.brk) begin
            win_in    = wwin;
            cnt_in    = wn;
            active_in = 1'b0;
         end else begin
            win_in         = rem;
            cnt_in         = rn;
            active_in      = !last;
            rsp_valid_in   = 1'b1;
            out_byte_in    = st.value;
            run_last_in    = last;
            string_last_in = last && weos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff         <= win_in;
      eos_ff         <= eos_in;
      out_byte_ff    <= out_byte_in;
      run_last_ff    <= run_last_in;
      string_last_ff <= string_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_string_last = string_last_ff;

endmodule
